// ===== hdl/m2i_pkg.sv =====
package m2i_pkg;

  // per-lane control that travels with each quotient
  typedef struct packed {
    logic active;  // determinant nonzero
    logic neg;     // quotient sign is negative
  } m2i_ctrl_t;

endpackage

// ===== hdl/matrix2x2_inverse_core.sv =====
// 2x2 matrix inverse in signed fixed point, fully pipelined: one transaction
// is accepted per cycle while the input is not stalled, and the result passes
// through two multiply/subtract stages, a magnitude stage, one restoring-division
// stage per quotient bit in each of four parallel lanes, a setup and an
// output stage. A stall at the output freezes the whole pipeline, and the
// input is stalled only while the output holds a result that is not taken.
// The determinant is exact; inverse entries are truncated toward zero and
// saturated, with saturated flagging any clip. A singular matrix gives
// invertible 0 and zero inverse entries.
module matrix2x2_inverse_core import m2i_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DATA_WIDTH-1:0]  entry_r0c0,
  input  logic signed [DATA_WIDTH-1:0]  entry_r0c1,
  input  logic signed [DATA_WIDTH-1:0]  entry_r1c0,
  input  logic signed [DATA_WIDTH-1:0]  entry_r1c1,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [2*DATA_WIDTH:0]  determinant,
  output logic signed [DATA_WIDTH-1:0]  inverse_r0c0,
  output logic signed [DATA_WIDTH-1:0]  inverse_r0c1,
  output logic signed [DATA_WIDTH-1:0]  inverse_r1c0,
  output logic signed [DATA_WIDTH-1:0]  inverse_r1c1,
  output logic                          invertible,
  output logic                          saturated
);

  localparam int DW = DATA_WIDTH;
  localparam int DTW = 2*DW + 1;
  localparam int LL = DW + 2;  // lane latency

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: products and entries
  logic signed [2*DW-1:0] p_ad, p_bc;
  logic signed [DW-1:0]   ea, eb, ec, ed;
  logic                   v1;

  // stage 2: determinant
  logic signed [DTW-1:0]  det2;
  logic signed [DW-1:0]   a2, b2, c2, d2;
  logic                   v2;

  // stage 3: magnitudes and lane control
  logic [2*DW-1:0]        den3;
  logic [DW-1:0]          mag3 [0:3];
  m2i_ctrl_t              ctl3 [0:3];
  logic signed [DTW-1:0]  det3;
  logic                   v3;

  logic signed [DTW-1:0]  det_d [0:LL-1];
  logic                   act_d [0:LL-1];
  logic                   val_d [0:LL-1];

  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] x);
    return x[DW-1] ? (DW'(0) - x) : x;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_ad <= entry_r0c0 * entry_r1c1;
      p_bc <= entry_r0c1 * entry_r1c0;
      ea   <= entry_r0c0;
      eb   <= entry_r0c1;
      ec   <= entry_r1c0;
      ed   <= entry_r1c1;

      det2 <= DTW'(p_ad) - DTW'(p_bc);
      a2 <= ea; b2 <= eb; c2 <= ec; d2 <= ed;

      den3 <= det2[DTW-1] ? (2*DW)'(-det2) : (2*DW)'(det2);
      det3 <= det2;
      mag3[0] <= mag_of(d2);
      mag3[1] <= mag_of(b2);
      mag3[2] <= mag_of(c2);
      mag3[3] <= mag_of(a2);
      // numerators are d, -b, -c, a
      ctl3[0] <= '{active: det2 != '0, neg: d2[DW-1] ^ det2[DTW-1]};
      ctl3[1] <= '{active: det2 != '0,
                   neg: (!b2[DW-1] && b2 != '0) ^ det2[DTW-1]};
      ctl3[2] <= '{active: det2 != '0,
                   neg: (!c2[DW-1] && c2 != '0) ^ det2[DTW-1]};
      ctl3[3] <= '{active: det2 != '0, neg: a2[DW-1] ^ det2[DTW-1]};

      det_d[0] <= det3;
      act_d[0] <= ctl3[0].active;
      for (int i = 1; i < LL; i++) begin
        det_d[i] <= det_d[i-1];
        act_d[i] <= act_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int i = 0; i < LL; i++) val_d[i] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      val_d[0] <= v3;
      for (int i = 1; i < LL; i++) val_d[i] <= val_d[i-1];
    end
  end

  logic signed [DW-1:0] qo [0:3];
  logic                 so [0:3];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    m2i_lane #(.DW(DW), .FB(FRAC_BITS)) u_lane (
      .clk     (clk),
      .en      (en),
      .ctrl    (ctl3[l]),
      .num_mag (mag3[l]),
      .den     (den3),
      .quot    (qo[l]),
      .sat     (so[l])
    );
  end

  assign out_valid    = val_d[LL-1];
  assign determinant  = det_d[LL-1];
  assign invertible   = act_d[LL-1];
  assign inverse_r0c0 = qo[0];
  assign inverse_r0c1 = qo[1];
  assign inverse_r1c0 = qo[2];
  assign inverse_r1c1 = qo[3];
  assign saturated    = so[0] | so[1] | so[2] | so[3];

endmodule

// ===== hdl/m2i_lane.sv =====
module m2i_lane import m2i_pkg::*; #(
  parameter int DW = 16,
  parameter int FB = 8
) (
  input  logic                clk,
  input  logic                en,
  input  m2i_ctrl_t           ctrl,
  input  logic [DW-1:0]       num_mag,
  input  logic [2*DW-1:0]     den,
  output logic signed [DW-1:0] quot,
  output logic                sat
);

  localparam int NW = DW + 2*FB;
  localparam int CW = ((NW > 3*DW) ? NW : 3*DW) + 1;

  logic [NW-1:0] rem  [0:DW];
  logic [DW-1:0] qv   [0:DW];
  logic          ovf  [0:DW];
  m2i_ctrl_t     ctl  [0:DW];
  logic [2*DW-1:0] dv [0:DW];

  logic [CW-1:0] un_w;
  logic          ovf_w;

  assign un_w  = CW'(num_mag) << (2*FB);
  // quotient would need more than DW bits
  assign ovf_w = un_w >= (CW'(den) << DW);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= NW'(un_w);
      qv[0]  <= '0;
      ovf[0] <= ovf_w;
      ctl[0] <= ctrl;
      dv[0]  <= den;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < DW; k++) begin : g_step
    localparam int B = DW - 1 - k;
    logic [CW-1:0] sub;
    logic          ge;
    assign sub = CW'(dv[k]) << B;
    assign ge  = CW'(rem[k]) >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? NW'(CW'(rem[k]) - sub) : rem[k];
        qv[k+1]  <= qv[k] | (ge ? (DW'(1) << B) : DW'(0));
        ovf[k+1] <= ovf[k];
        ctl[k+1] <= ctl[k];
        dv[k+1]  <= dv[k];
      end
    end
  end

  localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MAXN = {1'b1, {(DW-1){1'b0}}};

  logic [DW-1:0] q;
  logic          negeff;
  assign q      = qv[DW];
  assign negeff = ctl[DW].neg && (ovf[DW] || (q != '0));

  always_ff @(posedge clk) begin
    if (en) begin
      if (!ctl[DW].active) begin
        quot <= '0;
        sat  <= 1'b0;
      end else if (ovf[DW]) begin
        quot <= negeff ? MAXN : MAXP;
        sat  <= 1'b1;
      end else if (negeff) begin
        quot <= (q > MAXN) ? MAXN : (DW'(0) - q);
        sat  <= q > MAXN;
      end else begin
        quot <= (q > MAXP) ? MAXP : q;
        sat  <= q > MAXP;
      end
    end
  end

endmodule
